// ----- src/qsle_pkg.sv -----
`timescale 1ns / 1ps
// qsle_pkg: shared types and constants of the quicksort engine
// depends on nothing; imported by qsle_ram users and the top level
package qsle_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int ENT_W    = 2 * IDX_W;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } t_in;

    typedef struct packed {
        logic signed [VAL_W-1:0] sorted_value;
        logic                    final_res;
        logic                    overflow;
    } t_out;

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_POP,
        S_RANGE,
        S_PIV,
        S_RDJ,
        S_CMP,
        S_SWP1,
        S_SWP2,
        S_FS0,
        S_FS1,
        S_FS2,
        S_PUSH1,
        S_PUSH2,
        S_ORD
    } t_state;

endpackage

// ----- src/quicksort_lomuto_engine_unit.sv -----
`timescale 1ns / 1ps
// one element is accepted per cycle while idle; after the closing element the sort scans
// each range, swaps elements where needed, places the pivot and pushes the subranges;
// results then stream one per cycle; busy stays high from the closing transaction
// until the final result strobe; throughput is set by the single read port of the store
// reset: synchronous active-low i_rst_n empties the set; the receiver cannot stall
//
// quicksort_lomuto_engine_unit: element store, range stack and the sort sequencer
// depends on qsle_pkg and qsle_ram
module quicksort_lomuto_engine_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  qsle_pkg::t_in  i_item,
    output logic           busy,
    output logic           o_strobe,
    output qsle_pkg::t_out o_result
);
    import qsle_pkg::*;

    // sequencer state
    t_state r_state, n_state;

    // set bookkeeping
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_sp, n_sp;
    logic             r_dropped, n_dropped;

    // current partition
    logic [IDX_W-1:0] r_lo, n_lo;
    logic [IDX_W-1:0] r_hi, n_hi;
    logic [IDX_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_dest, n_dest;
    logic [IDX_W-1:0] r_k, n_k;
    logic [VAL_W-1:0] r_pivot, n_pivot;
    logic [VAL_W-1:0] r_vj, n_vj;
    logic [VAL_W-1:0] r_vd, n_vd;

    // result strobe and flags that travel with the registered read data
    logic r_strobe, n_strobe;
    logic r_final, n_final;
    logic r_ovf, n_ovf;

    // element store ports
    logic             st_we;
    logic [IDX_W-1:0] st_waddr;
    logic [VAL_W-1:0] st_wdata;
    logic [IDX_W-1:0] st_raddr;
    logic [VAL_W-1:0] st_rdata;

    // range stack ports
    logic             rs_we;
    logic [IDX_W-1:0] rs_waddr;
    logic [ENT_W-1:0] rs_wdata;
    logic [IDX_W-1:0] rs_raddr;
    logic [ENT_W-1:0] rs_rdata;

    // helpers
    logic             w_accept;
    logic             w_room;
    logic             w_less;
    logic             w_scan_end;
    logic [CNT_W-1:0] w_cnt_m1;
    logic [CNT_W-1:0] w_sp_m1;
    logic [IDX_W-1:0] w_ent_lo;
    logic [IDX_W-1:0] w_ent_hi;
    logic             w_skip;
    logic             w_push_left;
    logic             w_push_right;
    logic             w_stack_room;
    logic             w_out_last;
    logic [IDX_W-1:0] w_dest_m1;
    logic [IDX_W-1:0] w_dest_p1;

    qsle_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    qsle_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (rs_we),
        .i_waddr (rs_waddr),
        .i_wdata (rs_wdata),
        .i_raddr (rs_raddr),
        .o_rdata (rs_rdata)
    );

    assign busy     = (r_state != S_LOAD);
    assign w_accept = start && !busy;
    assign w_room   = (r_count < CNT_W'(CAPACITY));

    // the one shared compare: scanned element against the pivot, signed
    assign w_less = ($signed(st_rdata) < $signed(r_pivot));

    // scan ends when j reaches hi
    assign w_scan_end = (({1'b0, r_j} + CNT_W'(1)) == {1'b0, r_hi});

    assign w_cnt_m1 = r_count - CNT_W'(1);
    assign w_sp_m1  = r_sp - CNT_W'(1);

    // stack entry: lo in the upper half, hi in the lower half
    assign w_ent_lo = rs_rdata[ENT_W-1:IDX_W];
    assign w_ent_hi = rs_rdata[IDX_W-1:0];
    assign w_skip   = ({1'b0, w_ent_hi} >= r_count) || (w_ent_lo >= w_ent_hi);

    // only ranges of two or more elements are pushed
    assign w_push_left  = (({1'b0, r_lo} + CNT_W'(1)) < {1'b0, r_dest});
    assign w_push_right = (({1'b0, r_dest} + CNT_W'(1)) < {1'b0, r_hi});
    assign w_stack_room = (r_sp < CNT_W'(CAPACITY));
    assign w_dest_m1    = r_dest - IDX_W'(1);
    assign w_dest_p1    = r_dest + IDX_W'(1);

    assign w_out_last = ({1'b0, r_k} == w_cnt_m1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (w_accept && i_item.last) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                if (r_count == '0) begin
                    n_state = S_LOAD;
                end else if (r_count == CNT_W'(1)) begin
                    n_state = S_ORD;
                end else begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                n_state = (r_sp == '0) ? S_ORD : S_RANGE;
            end
            S_RANGE: begin
                n_state = w_skip ? S_POP : S_PIV;
            end
            S_PIV: begin
                n_state = S_RDJ;
            end
            S_RDJ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (w_less && (r_dest != r_j)) begin
                    n_state = S_SWP1;
                end else begin
                    n_state = w_scan_end ? S_FS0 : S_RDJ;
                end
            end
            S_SWP1: begin
                n_state = S_SWP2;
            end
            S_SWP2: begin
                n_state = w_scan_end ? S_FS0 : S_RDJ;
            end
            S_FS0: begin
                n_state = (r_dest == r_hi) ? S_PUSH1 : S_FS1;
            end
            S_FS1: begin
                n_state = S_FS2;
            end
            S_FS2: begin
                n_state = S_PUSH1;
            end
            S_PUSH1: begin
                n_state = S_PUSH2;
            end
            S_PUSH2: begin
                n_state = S_POP;
            end
            S_ORD: begin
                if (w_out_last) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_count   = r_count;
        n_sp      = r_sp;
        n_dropped = r_dropped;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_j       = r_j;
        n_dest    = r_dest;
        n_k       = r_k;
        n_pivot   = r_pivot;
        n_vj      = r_vj;
        n_vd      = r_vd;
        n_strobe  = 1'b0;
        n_final   = r_final;
        n_ovf     = r_ovf;

        st_we    = 1'b0;
        st_waddr = r_count[IDX_W-1:0];
        st_wdata = i_item.value;
        st_raddr = r_j;

        rs_we    = 1'b0;
        rs_waddr = r_sp[IDX_W-1:0];
        rs_wdata = {r_lo, w_dest_m1};
        rs_raddr = w_sp_m1[IDX_W-1:0];

        unique case (r_state)
            S_LOAD: begin
                // store the element, or drop it when the set is full
                if (w_accept) begin
                    if (w_room) begin
                        st_we   = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                end
            end
            S_INIT: begin
                n_k  = '0;
                n_sp = '0;
                if (r_count == '0) begin
                    n_dropped = 1'b0;
                end else if (r_count != CNT_W'(1)) begin
                    // whole set is the first range
                    rs_we    = 1'b1;
                    rs_waddr = '0;
                    rs_wdata = {IDX_W'(0), w_cnt_m1[IDX_W-1:0]};
                    n_sp     = CNT_W'(1);
                end
            end
            S_POP: begin
                n_k = '0;
                if (r_sp != '0) begin
                    n_sp = w_sp_m1;
                end
            end
            S_RANGE: begin
                n_lo     = w_ent_lo;
                n_hi     = w_ent_hi;
                n_j      = w_ent_lo;
                n_dest   = w_ent_lo;
                st_raddr = w_ent_hi;
            end
            S_PIV: begin
                n_pivot = st_rdata;
            end
            S_RDJ: begin
                st_raddr = r_j;
            end
            S_CMP: begin
                n_vj = st_rdata;
                if (w_less && (r_dest != r_j)) begin
                    st_raddr = r_dest;
                end else begin
                    if (w_less) begin
                        n_dest = w_dest_p1;
                    end
                    n_j = r_j + IDX_W'(1);
                end
            end
            S_SWP1: begin
                // element at j moves down to dest
                n_vd     = st_rdata;
                st_we    = 1'b1;
                st_waddr = r_dest;
                st_wdata = r_vj;
            end
            S_SWP2: begin
                st_we    = 1'b1;
                st_waddr = r_j;
                st_wdata = r_vd;
                n_dest   = w_dest_p1;
                n_j      = r_j + IDX_W'(1);
            end
            S_FS0: begin
                st_raddr = r_dest;
            end
            S_FS1: begin
                // element at dest moves up to hi; the pivot then goes to dest, its final place
                st_we    = 1'b1;
                st_waddr = r_hi;
                st_wdata = st_rdata;
            end
            S_FS2: begin
                st_we    = 1'b1;
                st_waddr = r_dest;
                st_wdata = r_pivot;
            end
            S_PUSH1: begin
                if (w_push_left && w_stack_room) begin
                    rs_we    = 1'b1;
                    rs_wdata = {r_lo, w_dest_m1};
                    n_sp     = r_sp + CNT_W'(1);
                end
            end
            S_PUSH2: begin
                if (w_push_right && w_stack_room) begin
                    rs_we    = 1'b1;
                    rs_wdata = {w_dest_p1, r_hi};
                    n_sp     = r_sp + CNT_W'(1);
                end
            end
            S_ORD: begin
                // stream the sorted store; flags are registered alongside the read data
                st_raddr = r_k;
                n_strobe = 1'b1;
                n_final  = w_out_last;
                n_ovf    = r_dropped;
                if (w_out_last) begin
                    n_count   = '0;
                    n_sp      = '0;
                    n_dropped = 1'b0;
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_sp      <= '0;
            r_dropped <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_sp      <= n_sp;
            r_dropped <= n_dropped;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_j     <= n_j;
        r_dest  <= n_dest;
        r_k     <= n_k;
        r_pivot <= n_pivot;
        r_vj    <= n_vj;
        r_vd    <= n_vd;
        r_final <= n_final;
        r_ovf   <= n_ovf;
    end

    assign o_strobe              = r_strobe;
    assign o_result.sorted_value = st_rdata;
    assign o_result.final_res    = r_final;
    assign o_result.overflow     = r_ovf;

    // the final result closes the run
    a_final_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.final_res) |=> !o_strobe)
        else $error("result strobe after final result");

    // pending ranges are disjoint, so the stack never holds more than half the set
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= CNT_W'(CAPACITY / 2))
        else $error("range stack deeper than expected");

    // scan invariant of the partition
    a_dest_behind_j: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_dest <= r_j))
        else $error("partition dest passed scan index");

    // an element offered to a full set marks the set as overflowed
    a_drop_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (r_count == CNT_W'(CAPACITY))) |=> r_dropped)
        else $error("dropped element not flagged");

endmodule

// ----- src/qsle_ram.sv -----
`timescale 1ns / 1ps
// qsle_ram: generic simple dual-port ram, one write and one registered read
// depends on nothing
module qsle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
